// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/bu2x_pkg.sv
package bu2x_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_COARSE_WIDTH = 512;
  localparam int DEF_SAMPLE_BITS      = 32;

  // fixed grid limits and field widths
  localparam int MAX_COARSE_HEIGHT = 512;
  localparam int ROW_BITS          = $clog2(MAX_COARSE_HEIGHT);
  localparam int COARSE_DIM_BITS   = 10;
  localparam int FINE_IDX_BITS     = 10;
  localparam int COARSE_DIM_RESET  = 259;

  // configuration register map
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_HEIGHT = 2'd1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // position and flags of one queued request
  typedef struct packed {
    logic [FINE_IDX_BITS-1:0] fine_row;
    logic [FINE_IDX_BITS-1:0] fine_col;
    logic                     end_of_grid;
  } job_hdr_t;

endpackage

// File: rtl/core/bu2x_front.sv
module bu2x_front #(
  parameter int MAX_COARSE_WIDTH = bu2x_pkg::DEF_MAX_COARSE_WIDTH,
  parameter int SAMPLE_BITS      = bu2x_pkg::DEF_SAMPLE_BITS,
  parameter int DATA_BITS        = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [bu2x_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [bu2x_pkg::COARSE_DIM_BITS-1:0]   cfg_data,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [SAMPLE_BITS-1:0]          edited_sample,
  input  logic signed [SAMPLE_BITS-1:0]          base_sample,
  output logic                                   q_push,
  output logic [DATA_BITS-1:0]                   q_data,
  input  logic                                   q_full
);
  import bu2x_pkg::*;

  localparam int XW = $clog2(MAX_COARSE_WIDTH);
  localparam int SW = SAMPLE_BITS + 1;
  localparam int RESET_W = (COARSE_DIM_RESET > MAX_COARSE_WIDTH) ?
                           MAX_COARSE_WIDTH : COARSE_DIM_RESET;
  localparam int RESET_H = (COARSE_DIM_RESET > MAX_COARSE_HEIGHT) ?
                           MAX_COARSE_HEIGHT : COARSE_DIM_RESET;

  // grid geometry and position
  logic [XW-1:0]       col_last;
  logic [XW-1:0]       col_last_next;
  logic [ROW_BITS-1:0] row_last;
  logic [ROW_BITS-1:0] row_last_next;
  logic [XW-1:0]       col;
  logic [ROW_BITS-1:0] row;

  // line store and neighbor registers
  logic [2*SAMPLE_BITS-1:0] line_store [MAX_COARSE_WIDTH];
  logic [2*SAMPLE_BITS-1:0] up_q;
  logic [2*SAMPLE_BITS-1:0] left_q;
  logic [2*SAMPLE_BITS-1:0] upleft_q;

  // classify stage
  logic                     s1_valid;
  logic                     s1_emit;
  logic [2*SAMPLE_BITS-1:0] s1_cur;
  job_hdr_t                 s1_hdr;
  logic                     s1_adv;
  logic                     accept;
  logic [XW:0]              col_dbl;

  // per-channel partial sums
  logic signed [SAMPLE_BITS-1:0] cur_e, cur_b, up_e, up_b;
  logic signed [SAMPLE_BITS-1:0] left_e, left_b, ul_e, ul_b;
  logic signed [SW-1:0] vert_e, vert_b, hor_e, hor_b, diag_e, diag_b;

  // handshake between input, classify stage and queue
  assign full   = s1_valid && s1_emit && q_full;
  assign accept = push && !full;
  assign s1_adv = s1_valid && !(s1_emit && q_full);
  assign q_push = s1_valid && s1_emit && !q_full;

  // clamp of the written width
  always_comb begin
    if (cfg_data < 10'd2) begin
      col_last_next = XW'(1);
    end else if (32'(cfg_data) > 32'(MAX_COARSE_WIDTH)) begin
      col_last_next = XW'(MAX_COARSE_WIDTH - 1);
    end else begin
      col_last_next = XW'(cfg_data - 10'd1);
    end
  end

  // clamp of the written height
  always_comb begin
    if (cfg_data < 10'd2) begin
      row_last_next = ROW_BITS'(1);
    end else if (32'(cfg_data) > 32'(MAX_COARSE_HEIGHT)) begin
      row_last_next = ROW_BITS'(MAX_COARSE_HEIGHT - 1);
    end else begin
      row_last_next = ROW_BITS'(cfg_data - 10'd1);
    end
  end

  // geometry registers and raster counters, a width or height write restarts the grid
  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= XW'(RESET_W - 1);
      row_last <= ROW_BITS'(RESET_H - 1);
      col      <= '0;
      row      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COARSE_WIDTH: begin
          col_last <= col_last_next;
          col      <= '0;
          row      <= '0;
        end
        REG_COARSE_HEIGHT: begin
          row_last <= row_last_next;
          col      <= '0;
          row      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // line store, read before write at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      up_q             <= line_store[col];
      line_store[col]  <= {edited_sample, base_sample};
    end
  end

  assign col_dbl = {col, 1'b0} - {{(XW-1){1'b0}}, 2'b10};

  // classify stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // classify stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit              <= (col != '0) && (row != '0);
      s1_cur               <= {edited_sample, base_sample};
      s1_hdr.fine_row      <= {row, 1'b0} - 10'd2;
      s1_hdr.fine_col      <= FINE_IDX_BITS'(col_dbl);
      s1_hdr.end_of_grid   <= (col == col_last) && (row == row_last);
    end
  end

  // left and upper-left neighbors follow the request order
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_q   <= s1_cur;
      upleft_q <= up_q;
    end
  end

  // pair sums handed to the back
  always_comb begin
    cur_e  = s1_cur[2*SAMPLE_BITS-1:SAMPLE_BITS];
    cur_b  = s1_cur[SAMPLE_BITS-1:0];
    up_e   = up_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
    up_b   = up_q[SAMPLE_BITS-1:0];
    left_e = left_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
    left_b = left_q[SAMPLE_BITS-1:0];
    ul_e   = upleft_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
    ul_b   = upleft_q[SAMPLE_BITS-1:0];
    vert_e = SW'(up_e) + SW'(cur_e);
    vert_b = SW'(up_b) + SW'(cur_b);
    hor_e  = SW'(left_e) + SW'(cur_e);
    hor_b  = SW'(left_b) + SW'(cur_b);
    diag_e = SW'(ul_e) + SW'(left_e);
    diag_b = SW'(ul_b) + SW'(left_b);
  end

  assign q_data = {s1_hdr, diag_e, vert_e, hor_e, cur_e, diag_b, vert_b, hor_b, cur_b};

endmodule

// File: rtl/core/bu2x_queue.sv
module bu2x_queue #(
  parameter int DATA_BITS = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 q_full,
  input  logic                 rd_en,
  output logic [DATA_BITS-1:0] rd_data,
  output logic                 q_empty
);
  import bu2x_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CW-1:0]        count;

  assign q_full  = (count == CW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/core/bu2x_back.sv
module bu2x_back #(
  parameter int SAMPLE_BITS = bu2x_pkg::DEF_SAMPLE_BITS,
  parameter int DATA_BITS   = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [DATA_BITS-1:0]                  q_data,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [bu2x_pkg::FINE_IDX_BITS-1:0]    fine_row,
  output logic [bu2x_pkg::FINE_IDX_BITS-1:0]    fine_col,
  output logic signed [SAMPLE_BITS+1:0]         edited_out,
  output logic signed [SAMPLE_BITS+1:0]         base_out,
  output logic                                  last_of_run,
  output logic                                  end_of_grid
);
  import bu2x_pkg::*;

  localparam int SW       = SAMPLE_BITS + 1;
  localparam int OW       = SAMPLE_BITS + 2;
  localparam int CH       = 3 * SW + SAMPLE_BITS;
  localparam int HDR_BITS = $bits(job_hdr_t);

  // which of the four fine samples is produced
  localparam logic [1:0] PH_QUAD = 2'd0;
  localparam logic [1:0] PH_VERT = 2'd1;
  localparam logic [1:0] PH_HORZ = 2'd2;
  localparam logic [1:0] PH_COPY = 2'd3;

  logic [1:0]           phase;
  logic                 out_valid;
  logic                 go;
  job_hdr_t             hdr;
  logic [CH-1:0]        ch_e;
  logic [CH-1:0]        ch_b;
  logic                 odd_row;
  logic                 odd_col;

  // one fine sample of one channel
  function automatic logic signed [OW-1:0] fine_value(input logic [CH-1:0] ch,
                                                       input logic [1:0] ph);
    logic signed [SW-1:0]          diag;
    logic signed [SW-1:0]          vert;
    logic signed [SW-1:0]          hor;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [OW-1:0]          res;
    diag = ch[CH-1 -: SW];
    vert = ch[CH-1-SW -: SW];
    hor  = ch[CH-1-2*SW -: SW];
    cur  = ch[SAMPLE_BITS-1:0];
    case (ph)
      PH_QUAD: res = OW'(diag) + OW'(vert);
      PH_VERT: res = {vert, 1'b0};
      PH_HORZ: res = {hor, 1'b0};
      PH_COPY: res = {cur, 2'b00};
      default: res = '0;
    endcase
    return res;
  endfunction

  assign hdr  = job_hdr_t'(q_data[DATA_BITS-1 -: HDR_BITS]);
  assign ch_e = q_data[2*CH-1:CH];
  assign ch_b = q_data[CH-1:0];

  assign empty   = !out_valid;
  assign go      = !q_empty && (!out_valid || pop);
  assign q_pop   = go && (phase == PH_COPY);
  assign odd_row = (phase == PH_HORZ) || (phase == PH_COPY);
  assign odd_col = (phase == PH_VERT) || (phase == PH_COPY);

  // phase sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_QUAD;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        phase <= (phase == PH_COPY) ? PH_QUAD : phase + 2'd1;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (go) begin
      fine_row    <= odd_row ? {hdr.fine_row[FINE_IDX_BITS-1:1], 1'b1} : hdr.fine_row;
      fine_col    <= odd_col ? {hdr.fine_col[FINE_IDX_BITS-1:1], 1'b1} : hdr.fine_col;
      edited_out  <= fine_value(ch_e, phase);
      base_out    <= fine_value(ch_b, phase);
      last_of_run <= (phase == PH_COPY);
      end_of_grid <= (phase == PH_COPY) && hdr.end_of_grid;
    end
  end

endmodule

// File: rtl/core/bilinear_upsample_2x_grid.sv
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// input    | push / full               | edited_sample, base_sample
// result   | empty / pop               | fine_row, fine_col, edited_out, base_out,
//          |                           | last_of_run, end_of_grid
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// a sample in the first coarse row or column gives no result
// any other sample gives four fine samples, one per cycle from the result register unless pop stalls it
// the first result reaches the ports through the classify stage, the queue and the output register
// reset clears control only; the line store is never cleared, no clearing pass
// pop low stalls the result register, then the queue, then raises full
`include "assert_macros.svh"

module bilinear_upsample_2x_grid #(
  parameter int MAX_COARSE_WIDTH = bu2x_pkg::DEF_MAX_COARSE_WIDTH,
  parameter int SAMPLE_BITS      = bu2x_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bu2x_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bu2x_pkg::COARSE_DIM_BITS-1:0] cfg_data,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [SAMPLE_BITS-1:0]        edited_sample,
  input  logic signed [SAMPLE_BITS-1:0]        base_sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bu2x_pkg::FINE_IDX_BITS-1:0]   fine_row,
  output logic [bu2x_pkg::FINE_IDX_BITS-1:0]   fine_col,
  output logic signed [SAMPLE_BITS+1:0]        edited_out,
  output logic signed [SAMPLE_BITS+1:0]        base_out,
  output logic                                 last_of_run,
  output logic                                 end_of_grid
);
  import bu2x_pkg::*;

  localparam int SW        = SAMPLE_BITS + 1;
  localparam int DATA_BITS = $bits(job_hdr_t) + 2 * (3 * SW + SAMPLE_BITS);

  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  logic [DATA_BITS-1:0] q_wr_data;
  logic [DATA_BITS-1:0] q_rd_data;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // front: geometry, line store, neighbor sums
  bu2x_front #(
    .MAX_COARSE_WIDTH (MAX_COARSE_WIDTH),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .DATA_BITS        (DATA_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .edited_sample (edited_sample),
    .base_sample   (base_sample),
    .q_push        (q_push),
    .q_data        (q_wr_data),
    .q_full        (q_full)
  );

  // request queue between front and back
  bu2x_queue #(
    .DATA_BITS (DATA_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  // back: four fine samples per request
  bu2x_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_BITS   (DATA_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_rd_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .fine_row    (fine_row),
    .fine_col    (fine_col),
    .edited_out  (edited_out),
    .base_out    (base_out),
    .last_of_run (last_of_run),
    .end_of_grid (end_of_grid)
  );

  // checks
  `ASSERT_IMPLIES(a_last_odd, clk, rst, !empty && last_of_run, fine_row[0] && fine_col[0])
  `ASSERT_IMPLIES(a_end_last, clk, rst, !empty && end_of_grid, last_of_run)
  `ASSERT_IMPLIES(a_q_no_overflow, clk, rst, q_push, !q_full)
  `ASSERT_IMPLIES(a_q_no_underflow, clk, rst, q_pop, !q_empty)

endmodule
